// File: rtl/rlhex_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rlhex_pkg
// Types and constants shared by the radix literal to hex digits block.
// ----------------------------------------------------------------------------
package rlhex_pkg;

  typedef enum logic [1:0] {
    RADIX_DEC = 2'd0,
    RADIX_HEX = 2'd1,
    RADIX_BIN = 2'd2,
    RADIX_OCT = 2'd3
  } radix_t;

  typedef struct packed {
    logic [7:0] character;
    radix_t     radix;
    logic       last_char;
  } in_beat_t;

  typedef struct packed {
    logic [6:0] hex_char;
    logic       last_digit;
    logic       bad_digit;
  } out_beat_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] value;
  } digit_t;

  typedef enum logic [1:0] {
    ST_ACCUM = 2'd0,
    ST_SKIP  = 2'd1,
    ST_EMIT  = 2'd2
  } state_t;

  localparam logic [7:0] CHAR_ZERO    = 8'h30;
  localparam logic [7:0] CHAR_NINE    = 8'h39;
  localparam logic [7:0] CHAR_LC_A    = 8'h61;
  localparam logic [7:0] CHAR_LC_F    = 8'h66;
  localparam logic [7:0] CHAR_UC_A    = 8'h41;
  localparam logic [7:0] CHAR_UC_F    = 8'h46;
  localparam logic [3:0] LETTER_BIAS  = 4'd9;
  localparam logic [6:0] HEX_ZERO     = 7'h30;
  localparam logic [6:0] HEX_LETTER   = 7'h37;
  localparam logic [3:0] DEC_LIMIT    = 4'd10;
  localparam logic [3:0] OCT_LIMIT    = 4'd8;
  localparam logic [3:0] BIN_LIMIT    = 4'd2;

endpackage
`default_nettype wire

// File: rtl/rlhex_digit_dec.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rlhex_digit_dec
// Decodes one ASCII character into a digit value and checks it against the
// radix. An invalid character decodes to zero with ok low.
// ----------------------------------------------------------------------------
module rlhex_digit_dec
  import rlhex_pkg::*;
(
  input  wire logic [7:0] character,
  input  wire radix_t     radix,
  output digit_t          digit
);

  logic [3:0] raw;
  logic       is_char;
  logic       in_range;

  always_comb begin
    raw     = 4'd0;
    is_char = 1'b0;
    if (character inside {[CHAR_ZERO:CHAR_NINE]}) begin
      raw     = character[3:0];
      is_char = 1'b1;
    end else if (radix == RADIX_HEX && (character inside {[CHAR_LC_A:CHAR_LC_F]} ||
                                        character inside {[CHAR_UC_A:CHAR_UC_F]})) begin
      raw     = character[3:0] + LETTER_BIAS;
      is_char = 1'b1;
    end
    case (radix)
      RADIX_DEC: in_range = raw < DEC_LIMIT;
      RADIX_HEX: in_range = 1'b1;
      RADIX_BIN: in_range = raw < BIN_LIMIT;
      RADIX_OCT: in_range = raw < OCT_LIMIT;
      default:   in_range = 1'b0;
    endcase
    digit.ok    = is_char && in_range;
    digit.value = digit.ok ? raw : 4'd0;
  end

endmodule
`default_nettype wire

// File: rtl/radix_literal_to_hex_digits_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// radix_literal_to_hex_digits_unit
// Accumulates the characters of a numeric literal into a wrapping value and
// emits that value as upper-case ASCII hex digits, most significant first.
// Throughput: one character beat per cycle while accumulating. After a last
// character the input stalls until the last digit beat is issued. The nibble
// shift register holds NC = (VALUE_WIDTH+3)/4 nibbles; it drops one leading zero
// nibble per cycle, hands over, then sends one digit beat per cycle if not stalled.
// Reset: synchronous active-low; clears the value, error flag and controller.
// ----------------------------------------------------------------------------
module radix_literal_to_hex_digits_unit
  import rlhex_pkg::*;
#(
  parameter int VALUE_WIDTH = 64
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_stall,
  input  wire in_beat_t  in_data,
  output logic           out_valid,
  input  wire logic      out_stall,
  output out_beat_t      out_data
);

  localparam int NC = (VALUE_WIDTH + 3) / 4;
  localparam int NW = 4 * NC;
  localparam int CW = $clog2(NC + 1);

  state_t               state_r, state_nxt;
  logic [VALUE_WIDTH-1:0] acc_r, acc_nxt, acc_step;
  logic                 err_r, err_nxt;
  logic [NW-1:0]        sh_r, sh_nxt;
  logic [CW-1:0]        cnt_r, cnt_nxt;
  logic                 run_err_r, run_err_nxt;
  logic                 out_valid_r, out_valid_nxt;
  out_beat_t            out_r, out_nxt;
  digit_t               digit;
  logic [VALUE_WIDTH-1:0] digit_ext;
  logic [3:0]           top_nib;
  logic                 in_fire;
  logic                 out_free;

  rlhex_digit_dec u_dec (
    .character (in_data.character),
    .radix     (in_data.radix),
    .digit     (digit)
  );

  assign digit_ext = {{(VALUE_WIDTH-4){1'b0}}, digit.value};
  assign top_nib   = sh_r[NW-1 -: 4];
  assign in_stall  = (state_r != ST_ACCUM);
  assign in_fire   = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_comb begin
    case (in_data.radix)
      RADIX_DEC: acc_step = (acc_r << 3) + (acc_r << 1) + digit_ext;
      RADIX_HEX: acc_step = (acc_r << 4) | digit_ext;
      RADIX_BIN: acc_step = (acc_r << 1) | digit_ext;
      RADIX_OCT: acc_step = (acc_r << 3) | digit_ext;
      default:   acc_step = acc_r;
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    acc_nxt       = acc_r;
    err_nxt       = err_r;
    sh_nxt        = sh_r;
    cnt_nxt       = cnt_r;
    run_err_nxt   = run_err_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_nxt       = out_r;
    case (state_r)
      ST_ACCUM: begin
        if (in_fire) begin
          if (in_data.last_char) begin
            sh_nxt      = NW'(acc_step);
            cnt_nxt     = CW'(NC);
            run_err_nxt = err_r || !digit.ok;
            acc_nxt     = '0;
            err_nxt     = 1'b0;
            state_nxt   = ST_SKIP;
          end else begin
            acc_nxt = acc_step;
            err_nxt = err_r || !digit.ok;
          end
        end
      end
      ST_SKIP: begin
        if (top_nib == 4'd0 && cnt_r != CW'(1)) begin
          sh_nxt  = sh_r << 4;
          cnt_nxt = cnt_r - CW'(1);
        end else begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          out_valid_nxt      = 1'b1;
          out_nxt.hex_char   = (top_nib < DEC_LIMIT) ? HEX_ZERO + 7'(top_nib)
                                                     : HEX_LETTER + 7'(top_nib);
          out_nxt.last_digit = (cnt_r == CW'(1));
          out_nxt.bad_digit  = run_err_r;
          sh_nxt             = sh_r << 4;
          cnt_nxt            = cnt_r - CW'(1);
          if (cnt_r == CW'(1)) begin
            state_nxt = ST_ACCUM;
          end
        end
      end
      default: state_nxt = ST_ACCUM;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_ACCUM;
      acc_r       <= '0;
      err_r       <= 1'b0;
      cnt_r       <= '0;
      run_err_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      acc_r       <= acc_nxt;
      err_r       <= err_nxt;
      cnt_r       <= cnt_nxt;
      run_err_r   <= run_err_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sh_r  <= sh_nxt;
    out_r <= out_nxt;
  end

endmodule
`default_nettype wire
